/* design/efsd_pkg.sv */
// ----------------------------------------------------------------------------
// efsd_pkg
// shared constants and controller/datapath interface types for the
// earliest free server dispatch unit
// ----------------------------------------------------------------------------
package efsd_pkg;

    localparam int SERVERS_DEFAULT        = 16;
    localparam int FREE_TIME_BITS_DEFAULT = 48;

    localparam int SERVER_COUNT_BITS = 5;
    localparam int INDEX_BITS        = 4;
    localparam int SERVICE_BITS      = 16;
    localparam int START_BITS        = 48;
    localparam int PADDR_BITS        = 3;
    localparam int PDATA_BITS        = 32;

    localparam logic [SERVER_COUNT_BITS-1:0] SERVER_COUNT_RESET = 5'd16;

    localparam logic REG_SERVER_COUNT = 1'b0;

    localparam logic MODE_LOAD     = 1'b0;
    localparam logic MODE_DISPATCH = 1'b1;

    typedef struct packed {
        logic clr_en;
        logic latch;
        logic load_en;
        logic scan_rd;
        logic fetch;
        logic update;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic scan_last;
    } status_t;

endpackage

/* design/earliest_free_server_dispatch_unit.sv */
// ----------------------------------------------------------------------------
// earliest_free_server_dispatch_unit
// picks the active server with the least free time (lowest index on a tie),
// reports it with its start time and advances its free time, saturating
// ----------------------------------------------------------------------------
// channel   handshake                      word
// input     start, busy                    mode, server_index, service_time
// result    done (one-cycle strobe)        chosen_server, start_time, saturated
// config    psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// a load passes through the LOAD state and then returns to idle
// a dispatch runs the scan (one free time memory read per active server),
// then the DRAIN, FETCH and UPDATE states; done is high in the cycle busy drops
// after reset a clearing pass over every server entry keeps busy high
// results are never stalled; done marks each for exactly one cycle
// ----------------------------------------------------------------------------
module earliest_free_server_dispatch_unit
#(
    parameter int SERVERS        = efsd_pkg::SERVERS_DEFAULT,
    parameter int FREE_TIME_BITS = efsd_pkg::FREE_TIME_BITS_DEFAULT
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 mode,
    input  logic [efsd_pkg::INDEX_BITS-1:0]      server_index,
    input  logic [efsd_pkg::SERVICE_BITS-1:0]    service_time,
    output logic                                 done,
    output logic [efsd_pkg::INDEX_BITS-1:0]      chosen_server,
    output logic [efsd_pkg::START_BITS-1:0]      start_time,
    output logic                                 saturated,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [efsd_pkg::PADDR_BITS-1:0]      paddr,
    input  logic [efsd_pkg::PDATA_BITS-1:0]      pwdata,
    output logic [efsd_pkg::PDATA_BITS-1:0]      prdata,
    output logic                                 pready
);

    efsd_pkg::cmd_t    cmd;
    efsd_pkg::status_t status;

    logic [efsd_pkg::SERVER_COUNT_BITS-1:0] server_count_reg;
    logic                                   reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = paddr[2] == efsd_pkg::REG_SERVER_COUNT;
    assign prdata  = reg_hit ? efsd_pkg::PDATA_BITS'(server_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_count_reg <= efsd_pkg::SERVER_COUNT_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            server_count_reg <= pwdata[efsd_pkg::SERVER_COUNT_BITS-1:0];
        end
    end

    efsd_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (mode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    efsd_datapath
    #(
        .SERVERS        (SERVERS),
        .FREE_TIME_BITS (FREE_TIME_BITS)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .server_count  (server_count_reg),
        .server_index  (server_index),
        .service_time  (service_time),
        .done          (done),
        .chosen_server (chosen_server),
        .start_time    (start_time),
        .saturated     (saturated)
    );

    // a result always closes a busy period
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("result without preceding work");

    // a load gives no result
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == efsd_pkg::MODE_LOAD) |=> !done)
        else $error("result after load");

    // strobe lasts one cycle
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

endmodule

/* design/efsd_ctrl.sv */
// ----------------------------------------------------------------------------
// efsd_ctrl
// sequencer: clearing pass after reset, load, scan for the earliest free
// server, service time fetch and free time update
// ----------------------------------------------------------------------------
module efsd_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             mode,
    input  efsd_pkg::status_t status,
    output efsd_pkg::cmd_t   cmd,
    output logic             busy
);

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_LOAD   = 7'b0000100,
        ST_SCAN   = 7'b0001000,
        ST_DRAIN  = 7'b0010000,
        ST_FETCH  = 7'b0100000,
        ST_UPDATE = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.latch = 1'b1;
                    if (mode == efsd_pkg::MODE_LOAD)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_LOAD:
            begin
                cmd.load_en = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

/* design/efsd_datapath.sv */
// ----------------------------------------------------------------------------
// efsd_datapath
// service and free time memories, scan counter, running minimum and
// saturating free time update
// ----------------------------------------------------------------------------
module efsd_datapath
#(
    parameter int SERVERS        = efsd_pkg::SERVERS_DEFAULT,
    parameter int FREE_TIME_BITS = efsd_pkg::FREE_TIME_BITS_DEFAULT
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  efsd_pkg::cmd_t                         cmd,
    output efsd_pkg::status_t                      status,
    input  logic [efsd_pkg::SERVER_COUNT_BITS-1:0] server_count,
    input  logic [efsd_pkg::INDEX_BITS-1:0]        server_index,
    input  logic [efsd_pkg::SERVICE_BITS-1:0]      service_time,
    output logic                                   done,
    output logic [efsd_pkg::INDEX_BITS-1:0]        chosen_server,
    output logic [efsd_pkg::START_BITS-1:0]        start_time,
    output logic                                   saturated
);

    localparam int IDX_BITS = (SERVERS > 1) ? $clog2(SERVERS) : 1;

    logic [FREE_TIME_BITS-1:0]          free_mem [SERVERS];
    logic [efsd_pkg::SERVICE_BITS-1:0]  svc_mem  [SERVERS];

    logic [IDX_BITS-1:0]                cnt_reg;
    logic [efsd_pkg::INDEX_BITS-1:0]    idx_reg;
    logic [efsd_pkg::SERVICE_BITS-1:0]  svc_reg;
    logic [FREE_TIME_BITS-1:0]          free_rd_reg;
    logic                               rd_vld_reg;
    logic [IDX_BITS-1:0]                rd_idx_reg;
    logic [IDX_BITS-1:0]                best_idx_reg;
    logic [FREE_TIME_BITS-1:0]          best_val_reg;
    logic [efsd_pkg::SERVICE_BITS-1:0]  svc_rd_reg;
    logic                               done_reg;
    logic [efsd_pkg::INDEX_BITS-1:0]    chosen_reg;
    logic [efsd_pkg::START_BITS-1:0]    start_reg;
    logic                               sat_reg;

    logic [31:0]                        sc_ext;
    logic [31:0]                        last_ext;
    logic [IDX_BITS-1:0]                last_idx;
    logic [31:0]                        idx_ext;
    logic                               idx_ok;
    logic [IDX_BITS-1:0]                load_addr;
    logic [FREE_TIME_BITS:0]            sum;
    logic                               sum_sat;
    logic [FREE_TIME_BITS-1:0]          free_next;
    logic [63:0]                        best_val_ext;
    logic [31:0]                        best_idx_ext;
    logic                               take;

    // clamp active count to 1..SERVERS
    always_comb
    begin
        sc_ext = 32'(server_count);
        priority if (sc_ext == 32'd0)
        begin
            last_ext = 32'd0;
        end
        else if (sc_ext > 32'(SERVERS))
        begin
            last_ext = 32'(SERVERS - 1);
        end
        else
        begin
            last_ext = sc_ext - 32'd1;
        end
    end
    assign last_idx = last_ext[IDX_BITS-1:0];

    assign idx_ext   = 32'(idx_reg);
    assign idx_ok    = idx_ext < 32'(SERVERS);
    assign load_addr = idx_ext[IDX_BITS-1:0];

    assign status.clr_last  = cnt_reg == IDX_BITS'(SERVERS - 1);
    assign status.scan_last = cnt_reg == last_idx;

    assign sum       = {1'b0, best_val_reg} + (FREE_TIME_BITS + 1)'(svc_rd_reg);
    assign sum_sat   = sum[FREE_TIME_BITS];
    assign free_next = sum_sat ? '1 : sum[FREE_TIME_BITS-1:0];

    assign best_val_ext = 64'(best_val_reg);
    assign best_idx_ext = 32'(best_idx_reg);

    // strict less-than keeps the lowest index on a tie
    assign take = (rd_idx_reg == '0) || (free_rd_reg < best_val_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.scan_rd;
            done_reg   <= cmd.update;
            if (cmd.latch)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.clr_en || cmd.scan_rd)
            begin
                cnt_reg <= cnt_reg + IDX_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            idx_reg <= server_index;
            svc_reg <= service_time;
        end
        if (cmd.scan_rd)
        begin
            rd_idx_reg <= cnt_reg;
        end
        if (rd_vld_reg && take)
        begin
            best_idx_reg <= rd_idx_reg;
            best_val_reg <= free_rd_reg;
        end
        if (cmd.update)
        begin
            chosen_reg <= best_idx_ext[efsd_pkg::INDEX_BITS-1:0];
            start_reg  <= best_val_ext[efsd_pkg::START_BITS-1:0];
            sat_reg    <= sum_sat;
        end
    end

    // free time memory
    always_ff @(posedge clk)
    begin
        if (cmd.clr_en)
        begin
            free_mem[cnt_reg] <= '0;
        end
        else if (cmd.load_en && idx_ok)
        begin
            free_mem[load_addr] <= '0;
        end
        else if (cmd.update)
        begin
            free_mem[best_idx_reg] <= free_next;
        end
        if (cmd.scan_rd)
        begin
            free_rd_reg <= free_mem[cnt_reg];
        end
    end

    // service time memory
    always_ff @(posedge clk)
    begin
        if (cmd.clr_en)
        begin
            svc_mem[cnt_reg] <= '0;
        end
        else if (cmd.load_en && idx_ok)
        begin
            svc_mem[load_addr] <= svc_reg;
        end
        if (cmd.fetch)
        begin
            svc_rd_reg <= svc_mem[best_idx_reg];
        end
    end

    assign done          = done_reg;
    assign chosen_server = chosen_reg;
    assign start_time    = start_reg;
    assign saturated     = sat_reg;

endmodule

/* bench/earliest_free_server_dispatch_unit_tb.sv */
// ----------------------------------------------------------------------------
// earliest_free_server_dispatch_unit_tb
// drives load and dispatch words into the dispatch unit across several
// server count settings, tracks service and free times per server alongside
// the block and compares every dispatch result field by field
// ----------------------------------------------------------------------------
module earliest_free_server_dispatch_unit_tb;

    import efsd_pkg::*;

    localparam int NUM_SERVERS   = SERVERS_DEFAULT;
    localparam int SETTLE_CYCLES = NUM_SERVERS + 8;
    localparam int STALL_LIMIT   = 1000;
    localparam int PHASES        = 12;
    localparam int PHASE_WORDS   = 146;
    localparam logic [PADDR_BITS-1:0] ADDR_SERVER_COUNT = PADDR_BITS'(4 * REG_SERVER_COUNT);
    localparam logic [START_BITS-1:0] FREE_TIME_MAX     = {START_BITS{1'b1}};

    typedef struct packed {
        logic [INDEX_BITS-1:0] server;
        logic [START_BITS-1:0] begin_time;
        logic                  clipped;
    } dispatch_t;

    class dispatch_tracker;
        logic [SERVICE_BITS-1:0]      svc_times [NUM_SERVERS];
        logic [START_BITS-1:0]        free_times [NUM_SERVERS];
        logic [SERVER_COUNT_BITS-1:0] server_count;
        dispatch_t                    pending [$];
        int                           errors;

        function void clear();
            for (int i = 0; i < NUM_SERVERS; i++)
            begin
                svc_times[i]  = '0;
                free_times[i] = '0;
            end
            server_count = SERVER_COUNT_RESET;
            errors       = 0;
        endfunction

        function int active_servers();
            int n;
            n = int'(server_count);
            if (n == 0)
                n = 1;
            if (n > NUM_SERVERS)
                n = NUM_SERVERS;
            return n;
        endfunction

        function void note_word(logic m, logic [INDEX_BITS-1:0] idx,
                                logic [SERVICE_BITS-1:0] svc);
            int                    best;
            int                    n;
            logic [START_BITS:0]   sum;
            dispatch_t             d;
            if (m == MODE_LOAD)
            begin
                svc_times[idx]  = svc;
                free_times[idx] = '0;
                return;
            end
            n    = active_servers();
            best = 0;
            // strict less-than keeps the lowest index on a tie
            for (int i = 1; i < n; i++)
                if (free_times[i] < free_times[best])
                    best = i;
            sum          = {1'b0, free_times[best]} + (START_BITS + 1)'(svc_times[best]);
            d.server     = INDEX_BITS'(best);
            d.begin_time = free_times[best];
            d.clipped    = sum[START_BITS];
            free_times[best] = sum[START_BITS] ? FREE_TIME_MAX : sum[START_BITS-1:0];
            pending.push_back(d);
        endfunction

        function void check_dispatch(logic [INDEX_BITS-1:0] srv,
                                     logic [START_BITS-1:0] st, logic sat);
            dispatch_t d;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, got server %0d start %0d sat %0b",
                         $time, srv, st, sat);
                errors++;
                return;
            end
            d = pending.pop_front();
            if (srv !== d.server)
            begin
                $display("%0t: chosen_server expected %0d got %0d", $time, d.server, srv);
                errors++;
            end
            if (st !== d.begin_time)
            begin
                $display("%0t: start_time expected %0d got %0d", $time, d.begin_time, st);
                errors++;
            end
            if (sat !== d.clipped)
            begin
                $display("%0t: saturated expected %0b got %0b", $time, d.clipped, sat);
                errors++;
            end
        endfunction
    endclass

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic                         mode;
    logic [INDEX_BITS-1:0]        server_index;
    logic [SERVICE_BITS-1:0]      service_time;
    logic                         done;
    logic [INDEX_BITS-1:0]        chosen_server;
    logic [START_BITS-1:0]        start_time;
    logic                         saturated;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [PADDR_BITS-1:0]        paddr;
    logic [PDATA_BITS-1:0]        pwdata;
    logic [PDATA_BITS-1:0]        prdata;
    logic                         pready;

    dispatch_tracker tracker;
    int              stall_cycles = 0;

    earliest_free_server_dispatch_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .server_index  (server_index),
        .service_time  (service_time),
        .done          (done),
        .chosen_server (chosen_server),
        .start_time    (start_time),
        .saturated     (saturated),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.check_dispatch(chosen_server, start_time, saturated);
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable && pwrite && pready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("earliest_free_server_dispatch_unit test failed");
            $finish;
        end
    end

    function automatic int pick_gap(bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_word(logic m, logic [INDEX_BITS-1:0] idx,
                             logic [SERVICE_BITS-1:0] svc, int gap);
        @(negedge clk);
        start        <= 1'b1;
        mode         <= m;
        server_index <= idx;
        service_time <= svc;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        tracker.note_word(m, idx, svc);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
    endtask

    task automatic random_word(bit steady);
        logic                    m;
        logic [INDEX_BITS-1:0]   idx;
        logic [SERVICE_BITS-1:0] svc;
        int                      r;
        m   = ($urandom_range(0, 99) < 70) ? MODE_DISPATCH : MODE_LOAD;
        idx = INDEX_BITS'($urandom_range(0, NUM_SERVERS - 1));
        if (m == MODE_LOAD && $urandom_range(0, 1))
            idx = INDEX_BITS'($urandom_range(0, tracker.active_servers() - 1));
        r = $urandom_range(0, 9);
        if (r == 0)
            svc = '0;
        else if (r == 1)
            svc = '1;
        else if (r < 6)
            svc = SERVICE_BITS'($urandom_range(1, 8));
        else
            svc = SERVICE_BITS'($urandom_range(0, 65535));
        send_word(m, idx, svc, pick_gap(steady));
    endtask

    task automatic write_server_count(logic [SERVER_COUNT_BITS-1:0] value);
        logic [PDATA_BITS-1:0] junk;
        junk = $urandom();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_SERVER_COUNT;
        pwdata  <= {junk[PDATA_BITS-1:SERVER_COUNT_BITS], value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        tracker.server_count = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_quiet();
        @(negedge clk);
        start <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    initial
    begin
        int  phase_counts [10];
        bit  steady;
        int  count;

        phase_counts = '{0, 1, 31, 2, 17, 16, 5, 15, 3, 8};
        tracker = new();
        tracker.clear();
        rst_n        = 1'b0;
        start        = 1'b0;
        mode         = MODE_LOAD;
        server_index = '0;
        service_time = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // all free times equal and zero service: ties go to server 0
        send_word(MODE_DISPATCH, 4'hF, 16'hFFFF, 0);
        send_word(MODE_DISPATCH, 4'h0, 16'h0000, 1);
        send_word(MODE_LOAD, 4'h0, 16'hFFFF, 0);
        send_word(MODE_LOAD, 4'hF, 16'h0001, 0);
        send_word(MODE_LOAD, 4'h5, 16'h5555, 2);
        send_word(MODE_LOAD, 4'hA, 16'hAAAA, 0);
        send_word(MODE_DISPATCH, 4'h3, 16'h1234, 0);
        send_word(MODE_DISPATCH, 4'hC, 16'h0000, 0);
        for (int i = 1; i < NUM_SERVERS - 1; i++)
            if (i != 5 && i != 10)
                send_word(MODE_LOAD, INDEX_BITS'(i), 16'hFFFF, 0);
        send_word(MODE_DISPATCH, 4'h0, 16'h0000, 0);
        send_word(MODE_DISPATCH, 4'h0, 16'h0000, 3);
        // reload clears the free time of a busy server
        send_word(MODE_LOAD, 4'h0, 16'h0002, 0);
        send_word(MODE_DISPATCH, 4'hF, 16'hFFFF, 0);
        send_word(MODE_DISPATCH, 4'hF, 16'hFFFF, 0);
        wait_quiet();

        for (int p = 0; p < PHASES; p++)
        begin
            count = (p < 10) ? phase_counts[p] : $urandom_range(0, 31);
            write_server_count(SERVER_COUNT_BITS'(count));
            steady = (p % 3 == 1);
            for (int k = 0; k < PHASE_WORDS; k++)
                random_word(steady);
            wait_quiet();
        end

        if (tracker.errors == 0 && tracker.pending.size() == 0)
            $display("earliest_free_server_dispatch_unit test passed");
        else
            $display("earliest_free_server_dispatch_unit test failed");
        $finish;
    end

endmodule

/* sim.f */
design/efsd_pkg.sv
design/efsd_ctrl.sv
design/efsd_datapath.sv
design/earliest_free_server_dispatch_unit.sv
bench/earliest_free_server_dispatch_unit_tb.sv
